/* sv/qslerp_pkg.sv */
// shared types and constants for the quaternion slerp pipeline
`timescale 1ns / 1ps

package qslerp_pkg;

    localparam logic [1:0] PATH_A   = 2'd0;
    localparam logic [1:0] PATH_B   = 2'd1;
    localparam logic [1:0] PATH_LIN = 2'd2;
    localparam logic [1:0] PATH_SPH = 2'd3;

    localparam int TAB_DEPTH = 24;
    localparam int SQRT_STEPS = 31;
    localparam int QUO_BITS = 38;

    localparam logic signed [33:0] GAIN_INV = 34'sd652032874;
    localparam logic [30:0] ONE_Q30 = 31'd1073741824;
    localparam logic [30:0] SIN_FLOOR = 31'd4194304;

    // atan(2^-i) in q30 radians, truncated
    localparam logic signed [33:0] ATAN_TAB [0:TAB_DEPTH-1] = '{
        34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
        34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
        34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
        34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
        34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
        34'sd1023,      34'sd511,       34'sd255,       34'sd127
    };

    typedef struct packed {
        logic [3:0][15:0] a;
        logic [3:0][16:0] b;
        logic [16:0]      t;
        logic [1:0]       path;
        logic [29:0]      d30;
        logic [30:0]      s;
    } ctx_t;

endpackage

/* sv/quaternion_slerp_shortest_top.sv */
// quaternion slerp, shortest path, fully pipelined
`timescale 1ns / 1ps

// Usage:
// s_axis carries one item per transfer: tdata holds a_w, a_x, a_y, a_z, b_w, b_x,
// b_y, b_z (16 bits each, signed q1.15) then weight (17 bits, unsigned q1.16) from bit 0 up.
// m_axis carries one result per item: tdata holds r_w, r_x, r_y, r_z from bit 0 up,
// tuser holds path_taken (0 first, 1 second, 2 linear, 3 spherical).
// cfg_wen/cfg_wdata write close_threshold; write only while the pipeline is empty.
// One item enters per cycle unless the receiver stalls. The depth is set by
// the 31-stage square root, two CORDIC chains of CORDIC_STEPS stages each and the
// 38-stage weight divider, plus dot product, angle, blend and output stages.
// Every item takes the same path length, so results leave in input order.
// When the receiver stalls, the whole pipeline holds and s_axis_tready drops
// until the output register is taken; nothing is lost or repeated.
// Reset empties the pipeline and sets close_threshold to 32765.
module quaternion_slerp_shortest_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wen,
    input  logic [14:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, weight, zero pad
    input  logic [151:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // r_w, r_x, r_y, r_z
    output logic [63:0]  m_axis_tdata,
    // path_taken
    output logic [1:0]   m_axis_tuser
);
    import qslerp_pkg::*;

    localparam int N     = CORDIC_STEPS;
    localparam int P_IN  = 0;
    localparam int P_SUM = 1;
    localparam int P_ABS = 2;
    localparam int P_SQ  = 3;
    localparam int P_RAD = 4;
    localparam int SQ0   = 5;
    localparam int AT0   = SQ0 + SQRT_STEPS;
    localparam int ANG   = AT0 + N;
    localparam int SIN0  = ANG + 1;
    localparam int CLP   = SIN0 + N;
    localparam int DIV0  = CLP + 1;
    localparam int MUL   = DIV0 + QUO_BITS;
    localparam int OUTS  = MUL + 1;
    localparam int LAT   = OUTS + 1;

    logic            en;
    logic [14:0]     close_threshold_reg;
    logic [LAT-1:0]  vld_reg;
    ctx_t            ctx_reg  [0:LAT-1];
    ctx_t            ctx_next [0:LAT-1];

    assign en = m_axis_tready || !vld_reg[OUTS];
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            close_threshold_reg <= 15'd32765;
        end
        else if (cfg_wen)
        begin
            close_threshold_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    // dot product stages
    logic signed [31:0] prod_reg [0:3];
    logic signed [33:0] dot_reg;
    logic        [59:0] dsq_reg;
    logic        [60:0] rad_reg;
    logic signed [33:0] dot_abs;
    logic               dot_neg;
    logic        [61:0] sq_v_reg [0:SQRT_STEPS-1];
    logic        [61:0] sq_r_reg [0:SQRT_STEPS-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                prod_reg[i] <= $signed(s_axis_tdata[16*i +: 16])
                             * $signed(s_axis_tdata[64 + 16*i +: 16]);
            end
            dot_reg <= 34'(prod_reg[0]) + 34'(prod_reg[1])
                     + 34'(prod_reg[2]) + 34'(prod_reg[3]);
            dsq_reg <= 60'(ctx_reg[P_ABS].d30) * 60'(ctx_reg[P_ABS].d30);
            rad_reg <= (61'(1) << 60) - 61'(dsq_reg);
        end
    end

    assign dot_neg = dot_reg[33];
    assign dot_abs = dot_neg ? -dot_reg : dot_reg;

    // context line: carries the operands, weight and path along every stage
    for (genvar g = 0; g < LAT; g++)
    begin : g_ctx
        if (g == P_IN)
        begin : g_in
            always_comb
            begin
                ctx_next[g] = '0;
                for (int i = 0; i < 4; i++)
                begin
                    ctx_next[g].a[i] = s_axis_tdata[16*i +: 16];
                    ctx_next[g].b[i] = {s_axis_tdata[64 + 16*i + 15],
                                        s_axis_tdata[64 + 16*i +: 16]};
                end
                ctx_next[g].t = s_axis_tdata[144:128];
                if (s_axis_tdata[144:128] == 17'd0)
                begin
                    ctx_next[g].path = PATH_A;
                end
                else if (s_axis_tdata[144])
                begin
                    ctx_next[g].path = PATH_B;
                end
                else
                begin
                    ctx_next[g].path = PATH_LIN;
                end
            end
        end
        else if (g == P_ABS)
        begin : g_abs
            always_comb
            begin
                ctx_next[g] = ctx_reg[g-1];
                ctx_next[g].d30 = dot_abs[29:0];
                if (ctx_reg[g-1].path != PATH_A && ctx_reg[g-1].path != PATH_B)
                begin
                    if (dot_abs[32:0] > {3'b0, close_threshold_reg, 15'b0})
                    begin
                        ctx_next[g].path = PATH_LIN;
                    end
                    else
                    begin
                        ctx_next[g].path = PATH_SPH;
                    end
                    if (dot_neg)
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            ctx_next[g].b[i] = -ctx_reg[g-1].b[i];
                        end
                    end
                end
            end
        end
        else if (g == AT0)
        begin : g_sroot
            always_comb
            begin
                ctx_next[g] = ctx_reg[g-1];
                ctx_next[g].s = sq_r_reg[SQRT_STEPS-1][30:0];
            end
        end
        else
        begin : g_pass
            assign ctx_next[g] = ctx_reg[g-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ctx_reg[g] <= ctx_next[g];
            end
        end
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        localparam logic [61:0] BIT = 62'(1) << (2 * (SQRT_STEPS - 1 - k));
        logic [61:0] v_in;
        logic [61:0] r_in;
        logic [61:0] trial;
        logic [61:0] sq_v_next;
        logic [61:0] sq_r_next;

        if (k == 0)
        begin : g_first
            assign v_in = {1'b0, rad_reg};
            assign r_in = '0;
        end
        else
        begin : g_rest
            assign v_in = sq_v_reg[k-1];
            assign r_in = sq_r_reg[k-1];
        end

        always_comb
        begin
            trial = r_in + BIT;
            if (v_in >= trial)
            begin
                sq_v_next = v_in - trial;
                sq_r_next = (r_in >> 1) + BIT;
            end
            else
            begin
                sq_v_next = v_in;
                sq_r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_v_reg[k] <= sq_v_next;
                sq_r_reg[k] <= sq_r_next;
            end
        end
    end

    // vectoring cordic: angle of (cos, sin)
    logic signed [33:0] at_x_reg [0:N-1];
    logic signed [33:0] at_y_reg [0:N-1];
    logic signed [33:0] at_z_reg [0:N-1];

    for (genvar i = 0; i < N; i++)
    begin : g_atan
        logic signed [33:0] x_in;
        logic signed [33:0] y_in;
        logic signed [33:0] z_in;

        if (i == 0)
        begin : g_first
            assign x_in = $signed({4'b0, ctx_reg[AT0-1].d30});
            assign y_in = $signed({3'b0, sq_r_reg[SQRT_STEPS-1][30:0]});
            assign z_in = '0;
        end
        else
        begin : g_rest
            assign x_in = at_x_reg[i-1];
            assign y_in = at_y_reg[i-1];
            assign z_in = at_z_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_in > 34'sd0)
                begin
                    at_x_reg[i] <= x_in + (y_in >>> i);
                    at_y_reg[i] <= y_in - (x_in >>> i);
                    at_z_reg[i] <= z_in + ATAN_TAB[i];
                end
                else
                begin
                    at_x_reg[i] <= x_in - (y_in >>> i);
                    at_y_reg[i] <= y_in + (x_in >>> i);
                    at_z_reg[i] <= z_in - ATAN_TAB[i];
                end
            end
        end
    end

    // partial angles (1-t)w and tw
    logic [30:0] ang_w;
    logic [47:0] pw_reg [0:1];

    assign ang_w = at_z_reg[N-1][33] ? 31'd0 : at_z_reg[N-1][30:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pw_reg[0] <= 48'(ang_w) * 48'(17'd65536 - ctx_reg[ANG-1].t);
            pw_reg[1] <= 48'(ang_w) * 48'(ctx_reg[ANG-1].t);
        end
    end

    // rotation cordic, one lane per partial angle
    logic signed [33:0] sn_x_reg [0:1][0:N-1];
    logic signed [33:0] sn_y_reg [0:1][0:N-1];
    logic signed [33:0] sn_z_reg [0:1][0:N-1];
    logic        [30:0] sc_reg   [0:1];

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        for (genvar i = 0; i < N; i++)
        begin : g_sin
            logic signed [33:0] x_in;
            logic signed [33:0] y_in;
            logic signed [33:0] z_in;

            if (i == 0)
            begin : g_first
                assign x_in = GAIN_INV;
                assign y_in = '0;
                assign z_in = $signed({2'b0, pw_reg[l][47:16]});
            end
            else
            begin : g_rest
                assign x_in = sn_x_reg[l][i-1];
                assign y_in = sn_y_reg[l][i-1];
                assign z_in = sn_z_reg[l][i-1];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!z_in[33])
                    begin
                        sn_x_reg[l][i] <= x_in - (y_in >>> i);
                        sn_y_reg[l][i] <= y_in + (x_in >>> i);
                        sn_z_reg[l][i] <= z_in - ATAN_TAB[i];
                    end
                    else
                    begin
                        sn_x_reg[l][i] <= x_in + (y_in >>> i);
                        sn_y_reg[l][i] <= y_in - (x_in >>> i);
                        sn_z_reg[l][i] <= z_in + ATAN_TAB[i];
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (sn_y_reg[l][N-1][33])
                begin
                    sc_reg[l] <= '0;
                end
                else if (sn_y_reg[l][N-1] > $signed({3'b0, ONE_Q30}))
                begin
                    sc_reg[l] <= ONE_Q30;
                end
                else
                begin
                    sc_reg[l] <= sn_y_reg[l][N-1][30:0];
                end
            end
        end
    end

    // weight = (sine << 30) / sin(w), one quotient bit per stage
    logic [60:0]          dv_rem_reg [0:1][0:QUO_BITS-1];
    logic [QUO_BITS-1:0]  dv_q_reg   [0:1][0:QUO_BITS-1];

    for (genvar l = 0; l < 2; l++)
    begin : g_div_lane
        for (genvar k = 0; k < QUO_BITS; k++)
        begin : g_div
            localparam int J = QUO_BITS - 1 - k;
            logic [60:0]         rem_in;
            logic [QUO_BITS-1:0] q_in;
            logic [68:0]         dsr;

            if (k == 0)
            begin : g_first
                assign rem_in = {sc_reg[l], 30'b0};
                assign q_in   = '0;
            end
            else
            begin : g_rest
                assign rem_in = dv_rem_reg[l][k-1];
                assign q_in   = dv_q_reg[l][k-1];
            end

            assign dsr = 69'(ctx_reg[DIV0+k-1].s) << J;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if ({8'b0, rem_in} >= dsr)
                    begin
                        dv_rem_reg[l][k] <= rem_in - dsr[60:0];
                        dv_q_reg[l][k]   <= q_in | (QUO_BITS'(1) << J);
                    end
                    else
                    begin
                        dv_rem_reg[l][k] <= rem_in;
                        dv_q_reg[l][k]   <= q_in;
                    end
                end
            end
        end
    end

    // blend products
    logic signed [38:0] k0;
    logic signed [38:0] k1;
    logic signed [55:0] mp_reg [0:3][0:1];

    always_comb
    begin
        if (ctx_reg[MUL-1].path == PATH_LIN)
        begin
            k0 = $signed(39'(17'd65536 - ctx_reg[MUL-1].t) << 14);
            k1 = $signed(39'(ctx_reg[MUL-1].t) << 14);
        end
        else
        begin
            k0 = $signed({1'b0, dv_q_reg[0][QUO_BITS-1]});
            k1 = $signed({1'b0, dv_q_reg[1][QUO_BITS-1]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                mp_reg[i][0] <= k0 * $signed({ctx_reg[MUL-1].a[i][15], ctx_reg[MUL-1].a[i]});
                mp_reg[i][1] <= k1 * $signed(ctx_reg[MUL-1].b[i]);
            end
        end
    end

    // round, saturate, pick endpoints
    logic signed [57:0] acc   [0:3];
    logic signed [27:0] acc_q [0:3];
    logic        [15:0] r_next [0:3];
    logic        [15:0] r_reg  [0:3];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            acc[i]   = 58'(mp_reg[i][0]) + 58'(mp_reg[i][1]) + (58'sd1 <<< 29);
            acc_q[i] = 28'(acc[i] >>> 30);
            if (ctx_reg[OUTS-1].path == PATH_A)
            begin
                r_next[i] = ctx_reg[OUTS-1].a[i];
            end
            else if (ctx_reg[OUTS-1].path == PATH_B)
            begin
                r_next[i] = ctx_reg[OUTS-1].b[i][15:0];
            end
            else if (acc_q[i] > 28'sd32767)
            begin
                r_next[i] = 16'h7fff;
            end
            else if (acc_q[i] < -28'sd32768)
            begin
                r_next[i] = 16'h8000;
            end
            else
            begin
                r_next[i] = acc_q[i][15:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                r_reg[i] <= r_next[i];
            end
        end
    end

    assign m_axis_tvalid = vld_reg[OUTS];
    assign m_axis_tdata  = {r_reg[3], r_reg[2], r_reg[1], r_reg[0]};
    assign m_axis_tuser  = ctx_reg[OUTS].path;

    // spherical items always have a sine well away from zero
    ap_sph_sine: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[CLP] && ctx_reg[CLP].path == PATH_SPH) |-> (ctx_reg[CLP].s >= SIN_FLOOR))
        else $error("spherical item with tiny sine");

    // spherical weights stay near one, far below the quotient range
    ap_sph_weight: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[MUL-1] && ctx_reg[MUL-1].path == PATH_SPH)
        |-> (dv_q_reg[0][QUO_BITS-1][QUO_BITS-1:31] == '0
             && dv_q_reg[1][QUO_BITS-1][QUO_BITS-1:31] == '0))
        else $error("spherical weight out of range");

    // stalled pipeline keeps its occupancy
    ap_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

endmodule
